>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property shorthands for the credit relay pulse injector
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/crpi_pkg.sv
// ----------------------------------------------------------------------------
// crpi_pkg
// types and constants of the credit relay pulse injector
// ----------------------------------------------------------------------------
package crpi_pkg;

	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RELAY_PULSE = 1'b0,
		CFG_PULSE_GAP   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SOUND_NONE  = 2'd0,
		SOUND_PULSE = 2'd1,
		SOUND_LAST  = 2'd2
	} sound_t;

	localparam logic [15:0] RELAY_PULSE_RST = 16'd100;
	localparam logic [15:0] PULSE_GAP_RST   = 16'd300;
	localparam logic [15:0] PENDING_MAX     = 16'hFFFF;

	typedef struct packed {
		logic [15:0] relay_pulse_ms;
		logic [15:0] pulse_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  sound_code;
		logic        relay_on;
		logic        refresh_screen;
		logic        save_request;
		logic [15:0] pending_count;
		logic [15:0] injected_count;
		logic [31:0] daily_count;
		logic [31:0] grand_total;
		logic [31:0] session_count;
	} result_t;

endpackage

>>> hdl/crpi_engine.sv
// ----------------------------------------------------------------------------
// crpi_engine
// credit state registers and the per-poll update logic
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crpi_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              data_received,
	input  logic [7:0]        received_credits,
	input  logic [31:0]       now_ms,
	input  crpi_pkg::cfg_t    cfg,
	output crpi_pkg::result_t res
);
	import crpi_pkg::*;

	logic [15:0] pending_q;
	logic [15:0] injected_q;
	logic [31:0] daily_q;
	logic [31:0] overall_q;
	logic [31:0] session_q;
	logic        relay_q;
	logic [31:0] relay_start_q;
	logic [31:0] last_pulse_q;

	logic [16:0] sum;
	logic [15:0] pend_a;
	logic [15:0] inj_a;
	logic [31:0] on_time;
	logic [31:0] gap_time;
	logic        relay_a;
	logic        inject;
	logic [15:0] pend_n;
	logic [15:0] inj_n;

	always_comb begin
		sum = {1'b0, pending_q} + {9'd0, received_credits};
		pend_a = pending_q;
		inj_a = injected_q;
		if (data_received) begin
			pend_a = sum[16] ? PENDING_MAX : sum[15:0];
			if (received_credits != 8'd0 && pending_q == 16'd0) begin
				inj_a = 16'd0;
			end
		end
		on_time = now_ms - relay_start_q;
		gap_time = now_ms - last_pulse_q;
		relay_a = relay_q && (on_time < {16'd0, cfg.relay_pulse_ms});
		inject = (pend_a != 16'd0) && !relay_a && (gap_time >= {16'd0, cfg.pulse_gap_ms});
		pend_n = inject ? pend_a - 16'd1 : pend_a;
		inj_n = inject ? inj_a + 16'd1 : inj_a;

		res.sound_code = SOUND_NONE;
		if (inject) begin
			res.sound_code = (pend_n == 16'd0) ? SOUND_LAST : SOUND_PULSE;
		end
		res.relay_on = relay_a || inject;
		res.refresh_screen = data_received || inject;
		res.save_request = inject;
		res.pending_count = pend_n;
		res.injected_count = inj_n;
		res.daily_count = inject ? daily_q + 32'd1 : daily_q;
		res.grand_total = inject ? overall_q + 32'd1 : overall_q;
		res.session_count = inject ? session_q + 32'd1 : session_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			injected_q <= '0;
			daily_q <= '0;
			overall_q <= '0;
			session_q <= '0;
			relay_q <= 1'b0;
			relay_start_q <= '0;
			last_pulse_q <= '0;
		end else if (step) begin
			pending_q <= pend_n;
			injected_q <= inj_n;
			daily_q <= res.daily_count;
			overall_q <= res.grand_total;
			session_q <= res.session_count;
			relay_q <= res.relay_on;
			if (inject) begin
				relay_start_q <= now_ms;
				last_pulse_q <= now_ms;
			end
		end
	end

	`ASSERT_NEXT(a_inject_relay, clk, arst_n, step && inject, relay_q && relay_start_q == $past(now_ms), "relay not started by injected credit")
	`ASSERT_NEXT(a_inject_count, clk, arst_n, step && inject, overall_q == $past(overall_q) + 32'd1, "total not advanced on injection")
	`ASSERT_NEXT(a_hold_state, clk, arst_n, !step, $stable(pending_q) && $stable(daily_q) && $stable(relay_q), "credit state moved without a poll")
	`ASSERT_IMPL(a_inject_needs_credit, clk, arst_n, inject, pend_a != 16'd0 && !relay_a, "injection with nothing pending or relay busy")

endmodule

>>> hdl/credit_relay_pulse_injector_core.sv
// ----------------------------------------------------------------------------
// credit_relay_pulse_injector_core
// poll-driven credit relay pulse injector with counters and config registers
// ----------------------------------------------------------------------------
// Takes one poll word per cycle while out_ready is high and returns one result
// word per poll: the poll is captured in an input register, the credit state
// is updated by a single pass of compare/add logic, and the result is captured
// in an output register. The state advances as a poll leaves the input
// register, so polls stream back to back while out_ready stays high.
// Config writes (relay pulse and pulse gap, 16-bit ms) are always accepted.

module credit_relay_pulse_injector_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        data_received,
	input  logic [7:0]                  received_credits,
	input  logic [31:0]                 now_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  sound_code,
	output logic                        relay_on,
	output logic                        refresh_screen,
	output logic                        save_request,
	output logic [15:0]                 pending_count,
	output logic [15:0]                 injected_count,
	output logic [31:0]                 daily_count,
	output logic [31:0]                 grand_total,
	output logic [31:0]                 session_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [crpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                 cfg_data
);
	import crpi_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic        got_s1;
	logic [7:0]  credits_s1;
	logic [31:0] now_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	logic        advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relay_pulse_ms <= RELAY_PULSE_RST;
			cfg_q.pulse_gap_ms <= PULSE_GAP_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RELAY_PULSE: cfg_q.relay_pulse_ms <= cfg_data;
				CFG_PULSE_GAP:   cfg_q.pulse_gap_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input word register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			got_s1 <= data_received;
			credits_s1 <= received_credits;
			now_s1 <= now_ms;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	crpi_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.data_received    (got_s1),
		.received_credits (credits_s1),
		.now_ms           (now_s1),
		.cfg              (cfg_q),
		.res              (res)
	);

	assign out_valid = valid_s2;
	assign sound_code = res_s2.sound_code;
	assign relay_on = res_s2.relay_on;
	assign refresh_screen = res_s2.refresh_screen;
	assign save_request = res_s2.save_request;
	assign pending_count = res_s2.pending_count;
	assign injected_count = res_s2.injected_count;
	assign daily_count = res_s2.daily_count;
	assign grand_total = res_s2.grand_total;
	assign session_count = res_s2.session_count;

endmodule
